[rtl/vpt_pkg.sv]
`default_nettype none

package vpt_pkg;

  // Field widths
  localparam int TS_W      = 63;
  localparam int ID_W      = 64;
  localparam int TIME_W    = 64;
  localparam int PERIOD_W  = 32;
  localparam int RUN_W     = 16;
  localparam int REJECT_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Remainder unit: one quotient bit per cycle over the timestamp width
  localparam int DIV_CNT_W = $clog2(TS_W + 1);

  // Operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_FORGET = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOOD = 2'd3;

  // Configuration reset values
  localparam logic [PERIOD_W-1:0] NOMINAL_RST  = 32'd0;
  localparam logic [PERIOD_W-1:0] MIN_RST      = 32'd1000000;
  localparam logic [PERIOD_W-1:0] MAX_RST      = 32'd100000000;
  localparam logic [RUN_W-1:0]    MIN_GOOD_RST = 16'd3;

  typedef struct packed {
    logic                is_sample;
    logic                is_query;
    logic                is_forget;
    logic [ID_W-1:0]     frame_id;
    logic [TS_W-1:0]     timestamp;
  } vpt_cmd_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] nominal_period;
    logic [PERIOD_W-1:0] min_period;
    logic [PERIOD_W-1:0] max_period;
    logic [RUN_W-1:0]    min_good_samples;
  } vpt_cfg_t;

  typedef struct packed {
    logic                usable;
    logic                boundary_valid;
    logic [TIME_W-1:0]   boundary_time;
    logic [TIME_W-1:0]   measured_delta;
    logic [RUN_W-1:0]    good_run;
    logic [REJECT_W-1:0] reject_total;
  } vpt_res_t;

endpackage

`default_nettype wire

[rtl/vpt_front.sv]
`default_nettype none

module vpt_front import vpt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire logic [1:0]      in_operation,
  input  wire logic [ID_W-1:0] in_frame_id,
  input  wire logic [TS_W-1:0] in_timestamp,
  output logic                 in_full,
  input  wire logic            cmd_pop,
  output logic                 cmd_empty,
  output vpt_cmd_t             cmd_head
);

  vpt_cmd_t                q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    push_ok;
  vpt_cmd_t                cmd_in;

  localparam logic [CMDQ_PTR_W-1:0] PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);

  // Classify the operation; the unused selector maps to a pure status beat
  always_comb begin
    cmd_in.is_sample = (in_operation == OP_SAMPLE);
    cmd_in.is_query  = (in_operation == OP_QUERY);
    cmd_in.is_forget = (in_operation == OP_FORGET);
    cmd_in.frame_id  = in_frame_id;
    cmd_in.timestamp = in_timestamp;
  end

  assign in_full   = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_empty = (cnt_r == '0);
  assign push_ok   = in_push && !in_full;
  assign cmd_head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + CMDQ_PTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + CMDQ_PTR_W'(1);
    end
    if (push_ok && !cmd_pop) begin
      cnt_nxt = cnt_r + CMDQ_CNT_W'(1);
    end else if (!push_ok && cmd_pop) begin
      cnt_nxt = cnt_r - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/vpt_mod_unit.sv]
`default_nettype none

module vpt_mod_unit import vpt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [TS_W-1:0]     dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  output logic                     done,
  output logic [PERIOD_W-1:0]      rem
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [TS_W-1:0]       dvd_r;
  logic [PERIOD_W-1:0]   dsr_r;
  logic [PERIOD_W-1:0]   rem_r;
  logic [PERIOD_W:0]     trial;
  logic [PERIOD_W:0]     diff;
  logic                  fits;

  // Restoring step: bring down one dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[TS_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(TS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd_r <= {dvd_r[TS_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

[rtl/vpt_back.sv]
`default_nettype none

module vpt_back import vpt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  vpt_cfg_t      cfg,
  input  wire logic     cmd_empty,
  input  vpt_cmd_t      cmd_head,
  output logic          cmd_pop,
  input  wire logic     res_taken,
  output logic          res_valid,
  output vpt_res_t      res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 state_r, state_nxt;
  logic [TS_W-1:0]      last_time_r, last_time_nxt;
  logic                 time_known_r, time_known_nxt;
  logic [ID_W-1:0]      last_frame_r, last_frame_nxt;
  logic                 frame_known_r, frame_known_nxt;
  logic [TIME_W-1:0]    delta_r, delta_nxt;
  logic [RUN_W-1:0]     good_r, good_nxt;
  logic [REJECT_W-1:0]  reject_r, reject_nxt;
  logic [TS_W-1:0]      qt_r, qt_nxt;
  logic                 res_valid_r;
  vpt_res_t             res_r, res_nxt;
  logic                 res_load;

  logic                 iv_ok;
  logic                 slot_free;
  logic                 had;
  logic                 succ;
  logic [TIME_W-1:0]    d64;
  logic                 bad;
  logic                 bvalid;
  logic [TIME_W-1:0]    btime;
  logic                 div_start;
  logic                 div_done;
  logic [PERIOD_W-1:0]  div_rem;
  logic [TS_W-1:0]      elapsed;
  logic [PERIOD_W-1:0]  pad;
  logic [TIME_W-1:0]    btime_div;

  assign iv_ok = (cfg.nominal_period != '0) &&
                 (cfg.nominal_period >= cfg.min_period) &&
                 (cfg.nominal_period <= cfg.max_period);

  assign slot_free = !res_valid_r || res_taken;

  // Successor test: no wrap from the largest id
  assign had  = time_known_r && frame_known_r;
  assign succ = had && (last_frame_r != '1) &&
                (cmd_head.frame_id == last_frame_r + ID_W'(1));
  assign d64  = {1'b0, cmd_head.timestamp} - {1'b0, last_time_r};
  assign bad  = (cmd_head.timestamp < last_time_r) ||
                (d64 < {{(TIME_W-PERIOD_W){1'b0}}, cfg.min_period}) ||
                (d64 > {{(TIME_W-PERIOD_W){1'b0}}, cfg.max_period});

  // Round up to the next boundary: add what the remainder is short of a period
  assign elapsed   = cmd_head.timestamp - last_time_r;
  assign pad       = (div_rem == '0) ? '0 : cfg.nominal_period - div_rem;
  assign btime_div = {1'b0, qt_r} + {{(TIME_W-PERIOD_W){1'b0}}, pad};

  vpt_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (cfg.nominal_period),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt       = state_r;
    last_time_nxt   = last_time_r;
    time_known_nxt  = time_known_r;
    last_frame_nxt  = last_frame_r;
    frame_known_nxt = frame_known_r;
    delta_nxt       = delta_r;
    good_nxt        = good_r;
    reject_nxt      = reject_r;
    qt_nxt          = qt_r;
    cmd_pop         = 1'b0;
    div_start       = 1'b0;
    res_load        = 1'b0;
    bvalid          = 1'b0;
    btime           = '0;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && slot_free) begin
          cmd_pop  = 1'b1;
          res_load = 1'b1;
          if (cmd_head.is_sample) begin
            last_time_nxt   = cmd_head.timestamp;
            time_known_nxt  = 1'b1;
            last_frame_nxt  = cmd_head.frame_id;
            frame_known_nxt = 1'b1;
            if (succ) begin
              delta_nxt = d64;
              if (bad) begin
                reject_nxt = reject_r + REJECT_W'(1);
                good_nxt   = '0;
              end else if (good_r != '1) begin
                good_nxt = good_r + RUN_W'(1);
              end
            end
          end else if (cmd_head.is_forget) begin
            time_known_nxt  = 1'b0;
            frame_known_nxt = 1'b0;
          end else if (cmd_head.is_query && iv_ok && time_known_r) begin
            bvalid = 1'b1;
            if (cmd_head.timestamp <= last_time_r) begin
              btime = {1'b0, last_time_r};
            end else begin
              // hold the result until the remainder is in
              res_load  = 1'b0;
              div_start = 1'b1;
              qt_nxt    = cmd_head.timestamp;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load  = 1'b1;
          bvalid    = 1'b1;
          btime     = btime_div;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt.usable         = time_known_nxt && iv_ok && (good_nxt >= cfg.min_good_samples);
    res_nxt.boundary_valid = bvalid;
    res_nxt.boundary_time  = btime;
    res_nxt.measured_delta = delta_nxt;
    res_nxt.good_run       = good_nxt;
    res_nxt.reject_total   = reject_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_time_r   <= '0;
      time_known_r  <= 1'b0;
      last_frame_r  <= '0;
      frame_known_r <= 1'b0;
      delta_r       <= '0;
      good_r        <= '0;
      reject_r      <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_time_r   <= last_time_nxt;
      time_known_r  <= time_known_nxt;
      last_frame_r  <= last_frame_nxt;
      frame_known_r <= frame_known_nxt;
      delta_r       <= delta_nxt;
      good_r        <= good_nxt;
      reject_r      <= reject_nxt;
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (res_taken) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    qt_r <= qt_nxt;
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !res_valid_r)
    else $error("result slot occupied during remainder run");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder done outside divide state");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV) && !cmd_pop)
    else $error("divide start did not hold the back end");

endmodule

`default_nettype wire

[rtl/vblank_phase_tracker_unit.sv]
`default_nettype none

// Vblank phase tracker.
// Input channel (in_*): push an operation with in_push while in_full is low;
// sample (record id and displayed time, measure the frame interval), boundary
// query (next vblank at or after in_timestamp) or forget phase.
// Result channel (out_*): one result beat per input beat, in order; the
// oldest result sits on the ports while out_empty is low and leaves on out_pop.
// Configuration (cfg_*): always ready; write while the block is idle.
// Flow: a front queue of two entries feeds the back end; an accepted beat is
// written into the queue, then popped by the back end into the result register.
// A query that has to round up to a later boundary holds the back end in the
// bit-serial remainder unit (63 steps, one timestamp bit per cycle, then the
// done register hands the remainder over); the back end takes no other beat meanwhile.
// Other operations go through at one beat per cycle while the receiver takes results.
// When the receiver stalls, the result register holds and the back end stops
// draining the queue; in_full rises once both queue entries are taken.
// Reset empties the queue and result register, clears the phase and counters
// and loads the default window and sample threshold.
module vblank_phase_tracker_unit import vpt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [1:0]            in_operation,
  input  wire logic [ID_W-1:0]       in_frame_id,
  input  wire logic [TS_W-1:0]       in_timestamp,
  // result channel
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_usable,
  output logic                       out_boundary_valid,
  output logic [TIME_W-1:0]          out_boundary_time,
  output logic signed [TIME_W-1:0]   out_measured_delta,
  output logic [RUN_W-1:0]           out_good_run,
  output logic [REJECT_W-1:0]        out_reject_total,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [PERIOD_W-1:0]   cfg_wdata
);

  vpt_cfg_t  cfg_r;
  vpt_cmd_t  cmd_head;
  logic      cmd_pop;
  logic      cmd_empty;
  logic      res_valid;
  logic      res_taken;
  vpt_res_t  res;

  // Configuration registers: always ready; each accepted write is registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_period   <= NOMINAL_RST;
      cfg_r.min_period       <= MIN_RST;
      cfg_r.max_period       <= MAX_RST;
      cfg_r.min_good_samples <= MIN_GOOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NOMINAL:  cfg_r.nominal_period   <= cfg_wdata;
        CFG_MIN:      cfg_r.min_period       <= cfg_wdata;
        CFG_MAX:      cfg_r.max_period       <= cfg_wdata;
        CFG_MIN_GOOD: cfg_r.min_good_samples <= cfg_wdata[RUN_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front: classify operations and queue them
  vpt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_operation (in_operation),
    .in_frame_id  (in_frame_id),
    .in_timestamp (in_timestamp),
    .in_full      (in_full),
    .cmd_pop      (cmd_pop),
    .cmd_empty    (cmd_empty),
    .cmd_head     (cmd_head)
  );

  // Back: phase state, interval checks, boundary rounding, result register
  vpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_taken (res_taken),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_taken          = out_pop && res_valid;
  assign out_empty          = !res_valid;
  assign out_usable         = res.usable;
  assign out_boundary_valid = res.boundary_valid;
  assign out_boundary_time  = res.boundary_time;
  assign out_measured_delta = signed'(res.measured_delta);
  assign out_good_run       = res.good_run;
  assign out_reject_total   = res.reject_total;

endmodule

`default_nettype wire
